FILE: rtl/mrmc_pkg.sv
// Shared types and constants for the machine run-mode controller.
// Used by every module of the block; depends on nothing else.
package mrmc_pkg;

   // Run modes, one-hot internally; mode_code() maps them to the reported code
   typedef enum logic [6:0] {
      MODE_IDLE    = 7'b0000001,
      MODE_RUN     = 7'b0000010,
      MODE_PAUSE   = 7'b0000100,
      MODE_INSERT  = 7'b0001000,
      MODE_ERROR   = 7'b0010000,
      MODE_JAM     = 7'b0100000,
      MODE_RUNOUT  = 7'b1000000
   } mode_type;

   localparam logic [2:0] MODE_CODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_CODE_RUN    = 3'd1;
   localparam logic [2:0] MODE_CODE_PAUSE  = 3'd2;
   localparam logic [2:0] MODE_CODE_INSERT = 3'd3;
   localparam logic [2:0] MODE_CODE_ERROR  = 3'd4;
   localparam logic [2:0] MODE_CODE_JAM    = 3'd5;
   localparam logic [2:0] MODE_CODE_RUNOUT = 3'd6;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_EVENT = 1'b1;

   localparam logic [3:0] EV_START       = 4'd0;
   localparam logic [3:0] EV_PAUSE       = 4'd1;
   localparam logic [3:0] EV_RESUME      = 4'd2;
   localparam logic [3:0] EV_INSERT      = 4'd3;
   localparam logic [3:0] EV_EXIT_INSERT = 4'd4;
   localparam logic [3:0] EV_CLEAR_ERROR = 4'd5;
   localparam logic [3:0] EV_JAM         = 4'd6;
   localparam logic [3:0] EV_JAM_CLEARED = 4'd7;
   localparam logic [3:0] EV_JAM_FAILED  = 4'd8;
   localparam logic [3:0] EV_RUNOUT      = 4'd9;
   localparam logic [3:0] EV_ESTOP       = 4'd10;
   localparam logic [3:0] EV_CUT_REVERSE = 4'd11;
   localparam logic [3:0] EV_CUT_STOP    = 4'd12;

   localparam logic [2:0] DRIVE_NONE     = 3'd0;
   localparam logic [2:0] DRIVE_HALT     = 3'd1;
   localparam logic [2:0] DRIVE_FORWARD  = 3'd2;
   localparam logic [2:0] DRIVE_CONTINUE = 3'd3;
   localparam logic [2:0] DRIVE_HOLD     = 3'd4;
   localparam logic [2:0] DRIVE_BACK_OUT = 3'd5;

   localparam logic [2:0] BUZZ_NONE   = 3'd0;
   localparam logic [2:0] BUZZ_START  = 3'd1;
   localparam logic [2:0] BUZZ_PAUSE  = 3'd2;
   localparam logic [2:0] BUZZ_ALARM  = 3'd3;
   localparam logic [2:0] BUZZ_JAM    = 3'd4;
   localparam logic [2:0] BUZZ_RUNOUT = 3'd5;

   localparam logic [1:0] CSR_JAM_RETRY_LIMIT  = 2'd0;
   localparam logic [1:0] CSR_PAUSE_TIMEOUT_MS = 2'd1;
   localparam logic [1:0] CSR_JAM_REVERSE_MM   = 2'd2;

   localparam logic [3:0]  RESET_JAM_RETRY_LIMIT  = 4'd3;
   localparam logic [31:0] RESET_PAUSE_TIMEOUT_MS = 32'd300000;
   localparam logic [7:0]  RESET_JAM_REVERSE_MM   = 8'd10;

   localparam logic [31:0] MS_PER_SECOND = 32'd1000;
   localparam logic [3:0]  JAM_ATTEMPTS_MAX = 4'd15;

   typedef struct packed {
      logic       operation;
      logic [3:0] event_code;
   } item_type;

   typedef struct packed {
      logic [3:0]  jam_retry_limit;
      logic [31:0] pause_timeout_ms;
      logic [7:0]  jam_reverse_mm;
   } cfg_type;

   // Elapsed counters replace the absolute time stamps: each holds the
   // millisecond clock minus the corresponding mark, modulo 2^32.
   typedef struct packed {
      mode_type    mode;
      mode_type    prev_mode;
      logic [31:0] pause_elapsed;
      logic [31:0] second_elapsed;
      logic [31:0] run_ms;
      logic [3:0]  jam_attempts;
      logic [31:0] error_total;
      logic [31:0] jam_total;
      logic [31:0] seconds_total;
      logic        insert_flag;
      logic        cutter_flag;
   } state_type;

   typedef struct packed {
      logic [2:0] motor_command;
      logic [7:0] motor_distance_mm;
      logic [2:0] buzzer_pattern;
   } cmd_type;

   localparam cfg_type CFG_RESET = '{
      jam_retry_limit:  RESET_JAM_RETRY_LIMIT,
      pause_timeout_ms: RESET_PAUSE_TIMEOUT_MS,
      jam_reverse_mm:   RESET_JAM_REVERSE_MM
   };

   localparam state_type STATE_RESET = '{
      mode:           MODE_IDLE,
      prev_mode:      MODE_IDLE,
      pause_elapsed:  32'd0,
      second_elapsed: 32'd0,
      run_ms:         32'd0,
      jam_attempts:   4'd0,
      error_total:    32'd0,
      jam_total:      32'd0,
      seconds_total:  32'd0,
      insert_flag:    1'b0,
      cutter_flag:    1'b0
   };

   function automatic logic [2:0] mode_code(input mode_type m);
      logic [2:0] code;
      case (m)
         MODE_IDLE:   code = MODE_CODE_IDLE;
         MODE_RUN:    code = MODE_CODE_RUN;
         MODE_PAUSE:  code = MODE_CODE_PAUSE;
         MODE_INSERT: code = MODE_CODE_INSERT;
         MODE_ERROR:  code = MODE_CODE_ERROR;
         MODE_JAM:    code = MODE_CODE_JAM;
         MODE_RUNOUT: code = MODE_CODE_RUNOUT;
         default:     code = MODE_CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

FILE: rtl/mrmc_req_stage.sv
// Input register for the request channel of the run-mode controller.
// Uses mrmc_pkg for the item type.
module mrmc_req_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic [3:0]         req_event_code,
   input  logic               take,
   output logic               item_valid,
   output mrmc_pkg::item_type item
);

   logic               valid_ff;
   logic               valid_in;
   mrmc_pkg::item_type item_ff;

   // Accept whenever the held transaction is empty or leaves this cycle
   assign req_ready = !valid_ff || take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= '{operation: req_operation, event_code: req_event_code};
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: rtl/mrmc_step.sv
// Next-state and command logic of the run-mode controller for one transaction.
// Purely combinational; uses mrmc_pkg types and constants.
module mrmc_step (
   input  mrmc_pkg::state_type cur,
   input  mrmc_pkg::item_type  item,
   input  mrmc_pkg::cfg_type   cfg,
   output mrmc_pkg::state_type nxt,
   output mrmc_pkg::cmd_type   cmd
);

   logic                go;
   logic                resume;
   mrmc_pkg::mode_type  target;
   logic [31:0]         second_next;

   always_comb begin
      nxt         = cur;
      cmd         = '0;
      go          = 1'b0;
      resume      = 1'b0;
      target      = cur.mode;
      second_next = cur.second_elapsed + 32'd1;

      if (item.operation == mrmc_pkg::OP_TICK) begin
         nxt.pause_elapsed  = cur.pause_elapsed + 32'd1;
         nxt.second_elapsed = second_next;
         if (cur.mode == mrmc_pkg::MODE_RUN) begin
            nxt.run_ms = cur.run_ms + 32'd1;
            if (second_next >= mrmc_pkg::MS_PER_SECOND) begin
               nxt.second_elapsed = '0;
               nxt.seconds_total  = cur.seconds_total + 32'd1;
            end
         end
      end else if (item.event_code == mrmc_pkg::EV_ESTOP) begin
         nxt.cutter_flag = 1'b0;
         go              = 1'b1;
         target          = mrmc_pkg::MODE_ERROR;
      end else if (item.event_code == mrmc_pkg::EV_RUNOUT &&
                   (cur.mode == mrmc_pkg::MODE_RUN || cur.mode == mrmc_pkg::MODE_INSERT)) begin
         go     = 1'b1;
         target = mrmc_pkg::MODE_RUNOUT;
      end else begin
         case (cur.mode)
            mrmc_pkg::MODE_IDLE: begin
               if (item.event_code == mrmc_pkg::EV_START) begin
                  nxt.jam_attempts = '0;
                  go               = 1'b1;
                  target           = mrmc_pkg::MODE_RUN;
               end else if (item.event_code == mrmc_pkg::EV_INSERT) begin
                  go     = 1'b1;
                  target = mrmc_pkg::MODE_INSERT;
               end else if (item.event_code == mrmc_pkg::EV_CUT_REVERSE) begin
                  nxt.cutter_flag = 1'b1;
               end else if (item.event_code == mrmc_pkg::EV_CUT_STOP) begin
                  nxt.cutter_flag = 1'b0;
               end
            end
            mrmc_pkg::MODE_RUN: begin
               if (item.event_code == mrmc_pkg::EV_PAUSE) begin
                  go     = 1'b1;
                  target = mrmc_pkg::MODE_PAUSE;
               end else if (item.event_code == mrmc_pkg::EV_JAM) begin
                  go     = 1'b1;
                  target = (cur.jam_attempts >= cfg.jam_retry_limit) ?
                           mrmc_pkg::MODE_ERROR : mrmc_pkg::MODE_JAM;
               end
            end
            mrmc_pkg::MODE_PAUSE: begin
               if (item.event_code == mrmc_pkg::EV_RESUME ||
                   item.event_code == mrmc_pkg::EV_START) begin
                  nxt.jam_attempts = '0;
                  go               = 1'b1;
                  resume           = 1'b1;
                  target           = mrmc_pkg::MODE_RUN;
               end else if (item.event_code == mrmc_pkg::EV_INSERT) begin
                  go     = 1'b1;
                  target = mrmc_pkg::MODE_INSERT;
               end
            end
            mrmc_pkg::MODE_INSERT: begin
               if (item.event_code == mrmc_pkg::EV_EXIT_INSERT) begin
                  nxt.insert_flag = 1'b0;
                  go              = 1'b1;
                  target = (cur.prev_mode == mrmc_pkg::MODE_RUN ||
                            cur.prev_mode == mrmc_pkg::MODE_PAUSE) ?
                           mrmc_pkg::MODE_PAUSE : mrmc_pkg::MODE_IDLE;
               end
            end
            mrmc_pkg::MODE_ERROR: begin
               if (item.event_code == mrmc_pkg::EV_CLEAR_ERROR) begin
                  go     = 1'b1;
                  target = mrmc_pkg::MODE_IDLE;
               end
            end
            mrmc_pkg::MODE_JAM: begin
               if (item.event_code == mrmc_pkg::EV_JAM_CLEARED) begin
                  go     = 1'b1;
                  resume = 1'b1;
                  target = mrmc_pkg::MODE_RUN;
               end else if (item.event_code == mrmc_pkg::EV_JAM_FAILED) begin
                  go     = 1'b1;
                  target = mrmc_pkg::MODE_ERROR;
               end
            end
            mrmc_pkg::MODE_RUNOUT: begin
               if (item.event_code == mrmc_pkg::EV_INSERT) begin
                  go     = 1'b1;
                  target = mrmc_pkg::MODE_INSERT;
               end else if (item.event_code == mrmc_pkg::EV_CLEAR_ERROR) begin
                  go     = 1'b1;
                  target = mrmc_pkg::MODE_IDLE;
               end
            end
            default: begin
            end
         endcase
      end

      // Apply the transition; run_ms already holds the accumulated total,
      // so leaving running needs no addition.
      if (go) begin
         nxt.prev_mode = cur.mode;
         nxt.mode      = target;
         case (target)
            mrmc_pkg::MODE_IDLE: begin
               cmd.motor_command = mrmc_pkg::DRIVE_HALT;
               nxt.run_ms        = '0;
            end
            mrmc_pkg::MODE_RUN: begin
               if (resume) begin
                  cmd.motor_command = mrmc_pkg::DRIVE_CONTINUE;
               end else begin
                  cmd.motor_command = mrmc_pkg::DRIVE_FORWARD;
                  nxt.run_ms        = '0;
               end
               cmd.buzzer_pattern = mrmc_pkg::BUZZ_START;
            end
            mrmc_pkg::MODE_PAUSE: begin
               cmd.motor_command  = mrmc_pkg::DRIVE_HOLD;
               cmd.buzzer_pattern = mrmc_pkg::BUZZ_PAUSE;
               nxt.pause_elapsed  = '0;
            end
            mrmc_pkg::MODE_INSERT: begin
               nxt.insert_flag = 1'b1;
            end
            mrmc_pkg::MODE_ERROR: begin
               cmd.motor_command  = mrmc_pkg::DRIVE_HALT;
               cmd.buzzer_pattern = mrmc_pkg::BUZZ_ALARM;
               nxt.error_total    = cur.error_total + 32'd1;
            end
            mrmc_pkg::MODE_JAM: begin
               if (cur.jam_attempts != mrmc_pkg::JAM_ATTEMPTS_MAX) begin
                  nxt.jam_attempts = cur.jam_attempts + 4'd1;
               end
               cmd.motor_command     = mrmc_pkg::DRIVE_BACK_OUT;
               cmd.motor_distance_mm = cfg.jam_reverse_mm;
               cmd.buzzer_pattern    = mrmc_pkg::BUZZ_JAM;
               nxt.jam_total         = cur.jam_total + 32'd1;
            end
            mrmc_pkg::MODE_RUNOUT: begin
               cmd.motor_command  = mrmc_pkg::DRIVE_HALT;
               cmd.buzzer_pattern = mrmc_pkg::BUZZ_RUNOUT;
            end
            default: begin
            end
         endcase
      end

      // Drop a pause that has lasted too long back to idle
      if (nxt.mode == mrmc_pkg::MODE_PAUSE && nxt.pause_elapsed > cfg.pause_timeout_ms) begin
         nxt.prev_mode = mrmc_pkg::MODE_PAUSE;
         nxt.mode      = mrmc_pkg::MODE_IDLE;
         nxt.run_ms    = '0;
         cmd           = '0;
         cmd.motor_command = mrmc_pkg::DRIVE_HALT;
      end
   end

endmodule

FILE: rtl/machine_run_mode_controller.sv
// An accepted request passes the input register, then the state and response
// registers; rsp_valid rises when those load, unless a held response stalls them.
// One transaction per cycle while responses drain; the next-state logic is combinational.
// Reset (synchronous, active high): mode idle, all counters and flags zero,
// registers at their defaults (retry limit 3, pause timeout 300000 ms, 10 mm).
// Depends on mrmc_pkg, mrmc_req_stage and mrmc_step.
module machine_run_mode_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [3:0]  req_event_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_mode,
   output logic [2:0]  rsp_motor_command,
   output logic [7:0]  rsp_motor_distance_mm,
   output logic [2:0]  rsp_buzzer_pattern,
   output logic        rsp_insert_active,
   output logic        rsp_cutter_reversing,
   output logic [31:0] rsp_run_time_ms,
   output logic [3:0]  rsp_retry_count,
   output logic [31:0] rsp_errors_seen,
   output logic [31:0] rsp_jams_seen,
   output logic [31:0] rsp_runtime_seconds,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   logic                item_valid;
   mrmc_pkg::item_type  item;
   logic                advance;
   mrmc_pkg::cfg_type   cfg_ff;
   mrmc_pkg::state_type state_ff;
   mrmc_pkg::state_type state_in;
   mrmc_pkg::cmd_type   cmd_ff;
   mrmc_pkg::cmd_type   cmd_in;
   logic                rsp_valid_ff;

   // Move a transaction into the result register when it is free or drained
   assign advance = item_valid && (!rsp_valid_ff || rsp_ready);

   mrmc_req_stage u_req_stage (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_event_code (req_event_code),
      .take           (advance),
      .item_valid     (item_valid),
      .item           (item)
   );

   mrmc_step u_step (
      .cur  (state_ff),
      .item (item),
      .cfg  (cfg_ff),
      .nxt  (state_in),
      .cmd  (cmd_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= mrmc_pkg::CFG_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            mrmc_pkg::CSR_JAM_RETRY_LIMIT:  cfg_ff.jam_retry_limit  <= csr_write_data[3:0];
            mrmc_pkg::CSR_PAUSE_TIMEOUT_MS: cfg_ff.pause_timeout_ms <= csr_write_data;
            mrmc_pkg::CSR_JAM_REVERSE_MM:   cfg_ff.jam_reverse_mm   <= csr_write_data[7:0];
            default: begin
            end
         endcase
      end
   end

   // State only moves together with a result register load, so the
   // registered state always matches the response on display.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mrmc_pkg::STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff <= state_in;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cmd_ff <= cmd_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_mode              = mrmc_pkg::mode_code(state_ff.mode);
   assign rsp_motor_command     = cmd_ff.motor_command;
   assign rsp_motor_distance_mm = cmd_ff.motor_distance_mm;
   assign rsp_buzzer_pattern    = cmd_ff.buzzer_pattern;
   assign rsp_insert_active     = state_ff.insert_flag;
   assign rsp_cutter_reversing  = state_ff.cutter_flag;
   assign rsp_run_time_ms       = state_ff.run_ms;
   assign rsp_retry_count       = state_ff.jam_attempts;
   assign rsp_errors_seen       = state_ff.error_total;
   assign rsp_jams_seen         = state_ff.jam_total;
   assign rsp_runtime_seconds   = state_ff.seconds_total;

`ifndef SYNTH
   a_jam_reverse_in_jam: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && cmd_ff.motor_command == mrmc_pkg::DRIVE_BACK_OUT |->
         state_ff.mode == mrmc_pkg::MODE_JAM)
      else $error("jam reverse command outside jam clearing");

   a_insert_flag_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && state_ff.mode == mrmc_pkg::MODE_INSERT |-> state_ff.insert_flag)
      else $error("insert mode without insert flag");

   a_alarm_counts_error: assert property (@(posedge clock) disable iff (reset)
      advance && cmd_in.buzzer_pattern == mrmc_pkg::BUZZ_ALARM |=>
         state_ff.error_total == $past(state_ff.error_total) + 32'd1)
      else $error("error alarm without error count");

   a_rsp_from_transaction: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance))
      else $error("response without a transaction");
`endif

endmodule

FILE: dv/tb_machine_run_mode_controller.sv
// Self-checking testbench for machine_run_mode_controller: directed mode walks,
// register extremes, back-pressure, a long running stretch and random traffic.
// Depends on mrmc_pkg and the block's RTL; every response is predicted in-line.
module tb_machine_run_mode_controller;

   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [2:0]  mode;
      logic [2:0]  motor_command;
      logic [7:0]  motor_distance_mm;
      logic [2:0]  buzzer_pattern;
      logic        insert_active;
      logic        cutter_reversing;
      logic [31:0] run_time_ms;
      logic [3:0]  retry_count;
      logic [31:0] errors_seen;
      logic [31:0] jams_seen;
      logic [31:0] runtime_seconds;
   } status_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_operation;
   logic [3:0]  req_event_code;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_mode;
   logic [2:0]  rsp_motor_command;
   logic [7:0]  rsp_motor_distance_mm;
   logic [2:0]  rsp_buzzer_pattern;
   logic        rsp_insert_active;
   logic        rsp_cutter_reversing;
   logic [31:0] rsp_run_time_ms;
   logic [3:0]  rsp_retry_count;
   logic [31:0] rsp_errors_seen;
   logic [31:0] rsp_jams_seen;
   logic [31:0] rsp_runtime_seconds;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [31:0] csr_write_data;

   machine_run_mode_controller dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_operation         (req_operation),
      .req_event_code        (req_event_code),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_mode              (rsp_mode),
      .rsp_motor_command     (rsp_motor_command),
      .rsp_motor_distance_mm (rsp_motor_distance_mm),
      .rsp_buzzer_pattern    (rsp_buzzer_pattern),
      .rsp_insert_active     (rsp_insert_active),
      .rsp_cutter_reversing  (rsp_cutter_reversing),
      .rsp_run_time_ms       (rsp_run_time_ms),
      .rsp_retry_count       (rsp_retry_count),
      .rsp_errors_seen       (rsp_errors_seen),
      .rsp_jams_seen         (rsp_jams_seen),
      .rsp_runtime_seconds   (rsp_runtime_seconds),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   // Predicted controller state and registers
   logic [2:0]  cur_mode, prior_mode;
   logic [31:0] ms_clock, pause_start, run_acc, run_start, sec_mark;
   logic [3:0]  attempts;
   logic [31:0] err_count, jam_count, sec_count;
   logic        insert_on, cutter_on;
   logic [3:0]  retry_limit;
   logic [31:0] pause_limit;
   logic [7:0]  reverse_mm;
   logic [2:0]  cmd_motor, cmd_buzz;
   logic [7:0]  cmd_dist;

   status_type pending_status_q[$];
   int      send_gap_pct = 33;
   int      recv_gap_pct = 82;
   int      stall_left = 0;
   int      items_sent = 0;
   int      effective_items = 0;
   int      responses_checked = 0;
   int      mismatch_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic void clear_prediction();
      cur_mode = mrmc_pkg::MODE_CODE_IDLE;
      prior_mode = mrmc_pkg::MODE_CODE_IDLE;
      ms_clock = '0;
      pause_start = '0;
      run_acc = '0;
      run_start = '0;
      sec_mark = '0;
      attempts = '0;
      err_count = '0;
      jam_count = '0;
      sec_count = '0;
      insert_on = 1'b0;
      cutter_on = 1'b0;
      retry_limit = mrmc_pkg::RESET_JAM_RETRY_LIMIT;
      pause_limit = mrmc_pkg::RESET_PAUSE_TIMEOUT_MS;
      reverse_mm = mrmc_pkg::RESET_JAM_REVERSE_MM;
   endfunction

   function automatic void enter_mode(logic [2:0] next, logic resume);
      // fold the running stretch into the accumulator on any exit from running
      if (cur_mode == mrmc_pkg::MODE_CODE_RUN) run_acc += ms_clock - run_start;
      prior_mode = cur_mode;
      cur_mode = next;
      cmd_motor = mrmc_pkg::DRIVE_NONE;
      cmd_dist = '0;
      cmd_buzz = mrmc_pkg::BUZZ_NONE;
      case (next)
         mrmc_pkg::MODE_CODE_IDLE: begin
            cmd_motor = mrmc_pkg::DRIVE_HALT;
            run_acc = '0;
         end
         mrmc_pkg::MODE_CODE_RUN: begin
            if (resume) begin
               cmd_motor = mrmc_pkg::DRIVE_CONTINUE;
            end else begin
               run_acc = '0;
               cmd_motor = mrmc_pkg::DRIVE_FORWARD;
            end
            run_start = ms_clock;
            cmd_buzz = mrmc_pkg::BUZZ_START;
         end
         mrmc_pkg::MODE_CODE_PAUSE: begin
            cmd_motor = mrmc_pkg::DRIVE_HOLD;
            pause_start = ms_clock;
            cmd_buzz = mrmc_pkg::BUZZ_PAUSE;
         end
         mrmc_pkg::MODE_CODE_INSERT: insert_on = 1'b1;
         mrmc_pkg::MODE_CODE_ERROR: begin
            cmd_motor = mrmc_pkg::DRIVE_HALT;
            cmd_buzz = mrmc_pkg::BUZZ_ALARM;
            err_count++;
         end
         mrmc_pkg::MODE_CODE_JAM: begin
            if (attempts < mrmc_pkg::JAM_ATTEMPTS_MAX) attempts++;
            cmd_motor = mrmc_pkg::DRIVE_BACK_OUT;
            cmd_dist = reverse_mm;
            cmd_buzz = mrmc_pkg::BUZZ_JAM;
            jam_count++;
         end
         default: begin
            cmd_motor = mrmc_pkg::DRIVE_HALT;
            cmd_buzz = mrmc_pkg::BUZZ_RUNOUT;
         end
      endcase
   endfunction

   function automatic void apply_event(logic [3:0] ev);
      if (ev == mrmc_pkg::EV_ESTOP) begin
         cutter_on = 1'b0;
         enter_mode(mrmc_pkg::MODE_CODE_ERROR, 1'b0);
         return;
      end
      if (ev == mrmc_pkg::EV_RUNOUT && (cur_mode == mrmc_pkg::MODE_CODE_RUN ||
                                        cur_mode == mrmc_pkg::MODE_CODE_INSERT)) begin
         enter_mode(mrmc_pkg::MODE_CODE_RUNOUT, 1'b0);
         return;
      end
      case (cur_mode)
         mrmc_pkg::MODE_CODE_IDLE: begin
            if (ev == mrmc_pkg::EV_START) begin
               attempts = '0;
               enter_mode(mrmc_pkg::MODE_CODE_RUN, 1'b0);
            end else if (ev == mrmc_pkg::EV_INSERT) begin
               enter_mode(mrmc_pkg::MODE_CODE_INSERT, 1'b0);
            end else if (ev == mrmc_pkg::EV_CUT_REVERSE) begin
               cutter_on = 1'b1;
            end else if (ev == mrmc_pkg::EV_CUT_STOP) begin
               cutter_on = 1'b0;
            end
         end
         mrmc_pkg::MODE_CODE_RUN: begin
            if (ev == mrmc_pkg::EV_PAUSE) begin
               enter_mode(mrmc_pkg::MODE_CODE_PAUSE, 1'b0);
            end else if (ev == mrmc_pkg::EV_JAM) begin
               if (attempts >= retry_limit) enter_mode(mrmc_pkg::MODE_CODE_ERROR, 1'b0);
               else enter_mode(mrmc_pkg::MODE_CODE_JAM, 1'b0);
            end
         end
         mrmc_pkg::MODE_CODE_PAUSE: begin
            if (ev == mrmc_pkg::EV_RESUME || ev == mrmc_pkg::EV_START) begin
               attempts = '0;
               enter_mode(mrmc_pkg::MODE_CODE_RUN, 1'b1);
            end else if (ev == mrmc_pkg::EV_INSERT) begin
               enter_mode(mrmc_pkg::MODE_CODE_INSERT, 1'b0);
            end
         end
         mrmc_pkg::MODE_CODE_INSERT: begin
            if (ev == mrmc_pkg::EV_EXIT_INSERT) begin
               insert_on = 1'b0;
               if (prior_mode == mrmc_pkg::MODE_CODE_RUN ||
                   prior_mode == mrmc_pkg::MODE_CODE_PAUSE)
                  enter_mode(mrmc_pkg::MODE_CODE_PAUSE, 1'b0);
               else
                  enter_mode(mrmc_pkg::MODE_CODE_IDLE, 1'b0);
            end
         end
         mrmc_pkg::MODE_CODE_ERROR: begin
            if (ev == mrmc_pkg::EV_CLEAR_ERROR) enter_mode(mrmc_pkg::MODE_CODE_IDLE, 1'b0);
         end
         mrmc_pkg::MODE_CODE_JAM: begin
            if (ev == mrmc_pkg::EV_JAM_CLEARED) enter_mode(mrmc_pkg::MODE_CODE_RUN, 1'b1);
            else if (ev == mrmc_pkg::EV_JAM_FAILED) enter_mode(mrmc_pkg::MODE_CODE_ERROR, 1'b0);
         end
         default: begin
            if (ev == mrmc_pkg::EV_INSERT) enter_mode(mrmc_pkg::MODE_CODE_INSERT, 1'b0);
            else if (ev == mrmc_pkg::EV_CLEAR_ERROR) enter_mode(mrmc_pkg::MODE_CODE_IDLE, 1'b0);
         end
      endcase
   endfunction

   function automatic status_type predict_status(logic op, logic [3:0] ev);
      status_type s;
      cmd_motor = mrmc_pkg::DRIVE_NONE;
      cmd_dist = '0;
      cmd_buzz = mrmc_pkg::BUZZ_NONE;
      if (op == mrmc_pkg::OP_TICK) begin
         ms_clock++;
         if (cur_mode == mrmc_pkg::MODE_CODE_RUN &&
             ms_clock - sec_mark >= mrmc_pkg::MS_PER_SECOND) begin
            sec_mark = ms_clock;
            sec_count++;
         end
      end else begin
         apply_event(ev);
      end
      if (cur_mode == mrmc_pkg::MODE_CODE_PAUSE && ms_clock - pause_start > pause_limit)
         enter_mode(mrmc_pkg::MODE_CODE_IDLE, 1'b0);
      s.mode = cur_mode;
      s.motor_command = cmd_motor;
      s.motor_distance_mm = cmd_dist;
      s.buzzer_pattern = cmd_buzz;
      s.insert_active = insert_on;
      s.cutter_reversing = cutter_on;
      s.run_time_ms = run_acc + ((cur_mode == mrmc_pkg::MODE_CODE_RUN) ?
                                 ms_clock - run_start : 32'd0);
      s.retry_count = attempts;
      s.errors_seen = err_count;
      s.jams_seen = jam_count;
      s.runtime_seconds = sec_count;
      return s;
   endfunction

   // Event that means something in the current mode, estop aside
   function automatic logic [3:0] pick_event();
      logic [3:0] opts [4];
      case (cur_mode)
         mrmc_pkg::MODE_CODE_RUN:
            opts = '{mrmc_pkg::EV_PAUSE, mrmc_pkg::EV_JAM, mrmc_pkg::EV_RUNOUT,
                     mrmc_pkg::EV_JAM};
         mrmc_pkg::MODE_CODE_PAUSE:
            opts = '{mrmc_pkg::EV_RESUME, mrmc_pkg::EV_START, mrmc_pkg::EV_INSERT,
                     mrmc_pkg::EV_RESUME};
         mrmc_pkg::MODE_CODE_INSERT:
            opts = '{mrmc_pkg::EV_EXIT_INSERT, mrmc_pkg::EV_RUNOUT, mrmc_pkg::EV_EXIT_INSERT,
                     mrmc_pkg::EV_RUNOUT};
         mrmc_pkg::MODE_CODE_ERROR:
            opts = '{mrmc_pkg::EV_CLEAR_ERROR, mrmc_pkg::EV_CLEAR_ERROR,
                     mrmc_pkg::EV_CLEAR_ERROR, mrmc_pkg::EV_CLEAR_ERROR};
         mrmc_pkg::MODE_CODE_JAM:
            opts = '{mrmc_pkg::EV_JAM_CLEARED, mrmc_pkg::EV_JAM_FAILED,
                     mrmc_pkg::EV_JAM_CLEARED, mrmc_pkg::EV_JAM_CLEARED};
         mrmc_pkg::MODE_CODE_RUNOUT:
            opts = '{mrmc_pkg::EV_INSERT, mrmc_pkg::EV_CLEAR_ERROR, mrmc_pkg::EV_INSERT,
                     mrmc_pkg::EV_CLEAR_ERROR};
         default:
            opts = '{mrmc_pkg::EV_START, mrmc_pkg::EV_INSERT, mrmc_pkg::EV_CUT_REVERSE,
                     mrmc_pkg::EV_CUT_STOP};
      endcase
      return opts[2'($urandom_range(3))];
   endfunction

   task automatic send_item(logic op, logic [3:0] ev);
      status_type s;
      logic [2:0] mode_was;
      logic       cutter_was;
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid = 1'b0;
         req_operation = 1'($urandom);
         req_event_code = 4'($urandom);
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_operation = op;
      req_event_code = ev;
      forever begin
         @(posedge clock);
         if (req_ready === 1'b1) break;
      end
      mode_was = cur_mode;
      cutter_was = cutter_on;
      s = predict_status(op, ev);
      pending_status_q.push_back(s);
      items_sent++;
      if (op == mrmc_pkg::OP_TICK || s.mode != mode_was ||
          s.motor_command != mrmc_pkg::DRIVE_NONE || s.cutter_reversing != cutter_was)
         effective_items++;
   endtask

   task automatic send_ticks(int count);
      repeat (count) send_item(mrmc_pkg::OP_TICK, 4'($urandom));
   endtask

   task automatic send_events(logic [3:0] evs[$]);
      foreach (evs[i]) send_item(mrmc_pkg::OP_EVENT, evs[i]);
   endtask

   // Drop valid and hold until every predicted response has been checked
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_status_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] index, logic [31:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = index;
      csr_write_data = data;
      case (index)
         mrmc_pkg::CSR_JAM_RETRY_LIMIT:  retry_limit = data[3:0];
         mrmc_pkg::CSR_PAUSE_TIMEOUT_MS: pause_limit = data;
         mrmc_pkg::CSR_JAM_REVERSE_MM:   reverse_mm = data[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable = 1'b0;
      csr_index = 2'($urandom);
      csr_write_data = $urandom;
   endtask

   // Narrow registers get junk in their unused upper bits
   task automatic set_config(logic [3:0] lim, logic [31:0] pause_ms, logic [7:0] rev_mm);
      write_reg(mrmc_pkg::CSR_JAM_RETRY_LIMIT, ($urandom & 32'hFFFF_FFF0) | {28'd0, lim});
      write_reg(mrmc_pkg::CSR_PAUSE_TIMEOUT_MS, pause_ms);
      write_reg(mrmc_pkg::CSR_JAM_REVERSE_MM, ($urandom & 32'hFFFF_FF00) | {24'd0, rev_mm});
      write_reg(CSR_UNUSED, $urandom);
   endtask

   task automatic test_mode_walk();
      send_ticks(1);
      send_events({mrmc_pkg::EV_CUT_REVERSE, mrmc_pkg::EV_CUT_STOP, mrmc_pkg::EV_CUT_REVERSE,
                   mrmc_pkg::EV_START});
      send_ticks(2);
      send_events({mrmc_pkg::EV_PAUSE, mrmc_pkg::EV_RESUME, mrmc_pkg::EV_JAM,
                   mrmc_pkg::EV_JAM_CLEARED, mrmc_pkg::EV_JAM, mrmc_pkg::EV_JAM_FAILED,
                   mrmc_pkg::EV_ESTOP, mrmc_pkg::EV_CLEAR_ERROR, mrmc_pkg::EV_INSERT,
                   mrmc_pkg::EV_RUNOUT, mrmc_pkg::EV_INSERT, mrmc_pkg::EV_EXIT_INSERT,
                   4'd13, 4'd15, mrmc_pkg::EV_START, mrmc_pkg::EV_RUNOUT,
                   mrmc_pkg::EV_CLEAR_ERROR, mrmc_pkg::EV_EXIT_INSERT, 4'd14});
   endtask

   task automatic test_insert_paths();
      send_events({mrmc_pkg::EV_START, mrmc_pkg::EV_PAUSE, mrmc_pkg::EV_INSERT,
                   mrmc_pkg::EV_EXIT_INSERT, mrmc_pkg::EV_START});
      send_ticks(3);
      send_events({mrmc_pkg::EV_PAUSE, mrmc_pkg::EV_RESUME, mrmc_pkg::EV_INSERT,
                   mrmc_pkg::EV_RUNOUT, mrmc_pkg::EV_INSERT, mrmc_pkg::EV_ESTOP,
                   mrmc_pkg::EV_CLEAR_ERROR, mrmc_pkg::EV_INSERT, mrmc_pkg::EV_EXIT_INSERT});
   endtask

   task automatic test_limits_low();
      settle();
      set_config(4'd0, 32'd0, 8'd0);
      send_events({mrmc_pkg::EV_START, mrmc_pkg::EV_JAM, mrmc_pkg::EV_CLEAR_ERROR,
                   mrmc_pkg::EV_START, mrmc_pkg::EV_PAUSE});
      send_ticks(1);
      settle();
      set_config(4'd1, 32'd1, 8'd0);
      send_events({mrmc_pkg::EV_START, mrmc_pkg::EV_JAM, mrmc_pkg::EV_JAM_CLEARED,
                   mrmc_pkg::EV_JAM, mrmc_pkg::EV_CLEAR_ERROR, mrmc_pkg::EV_START,
                   mrmc_pkg::EV_PAUSE});
      send_ticks(2);
   endtask

   task automatic test_limits_high();
      settle();
      set_config(4'd15, 32'hFFFF_FFFF, 8'd255);
      send_item(mrmc_pkg::OP_EVENT, mrmc_pkg::EV_START);
      repeat (15) send_events({mrmc_pkg::EV_JAM, mrmc_pkg::EV_JAM_CLEARED});
      send_events({mrmc_pkg::EV_JAM, mrmc_pkg::EV_CLEAR_ERROR, mrmc_pkg::EV_START,
                   mrmc_pkg::EV_PAUSE});
      send_ticks(20);
      send_item(mrmc_pkg::OP_EVENT, mrmc_pkg::EV_RESUME);
   endtask

   task automatic test_random_traffic(int target);
      int stop_at;
      int pick;
      stop_at = effective_items + target;
      while (effective_items < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 5) send_ticks($urandom_range(40, 2));
         else if (pick < 45) send_item(mrmc_pkg::OP_TICK, 4'($urandom));
         else if (pick < 90) send_item(mrmc_pkg::OP_EVENT, pick_event());
         else if (pick < 93) send_item(mrmc_pkg::OP_EVENT, mrmc_pkg::EV_ESTOP);
         else send_item(mrmc_pkg::OP_EVENT, 4'($urandom));
      end
   endtask

   // Hold the receiver off while the sender keeps offering, so the input stalls
   task automatic test_backpressure();
      send_item(mrmc_pkg::OP_EVENT, mrmc_pkg::EV_START);
      stall_left = 50;
      test_random_traffic(40);
   endtask

   task automatic test_run_seconds();
      settle();
      set_config(4'd4, 32'hFFFF_FFFF, 8'($urandom));
      send_item(mrmc_pkg::OP_EVENT, mrmc_pkg::EV_START);
      send_ticks(1000 + $urandom_range(50));
      send_events({mrmc_pkg::EV_PAUSE, mrmc_pkg::EV_RESUME});
      send_ticks(5);
      send_events({mrmc_pkg::EV_ESTOP, mrmc_pkg::EV_CLEAR_ERROR});
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = ($urandom_range(99) >= recv_gap_pct);
         end
      end
   end

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch on %s in response %0d: expected 0x%0h, got 0x%0h",
                     field, responses_checked, want, got);
      end
   endtask

   always @(posedge clock) begin : check_responses
      status_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_status_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("response with no transaction pending (mode 0x%0h)", rsp_mode);
         end else begin
            want = pending_status_q.pop_front();
            check_field("mode", 32'(want.mode), 32'(rsp_mode));
            check_field("motor_command", 32'(want.motor_command), 32'(rsp_motor_command));
            check_field("motor_distance_mm", 32'(want.motor_distance_mm),
                        32'(rsp_motor_distance_mm));
            check_field("buzzer_pattern", 32'(want.buzzer_pattern), 32'(rsp_buzzer_pattern));
            check_field("insert_active", 32'(want.insert_active), 32'(rsp_insert_active));
            check_field("cutter_reversing", 32'(want.cutter_reversing),
                        32'(rsp_cutter_reversing));
            check_field("run_time_ms", want.run_time_ms, rsp_run_time_ms);
            check_field("retry_count", 32'(want.retry_count), 32'(rsp_retry_count));
            check_field("errors_seen", want.errors_seen, rsp_errors_seen);
            check_field("jams_seen", want.jams_seen, rsp_jams_seen);
            check_field("runtime_seconds", want.runtime_seconds, rsp_runtime_seconds);
            responses_checked++;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = mrmc_pkg::OP_TICK;
      req_event_code = mrmc_pkg::EV_START;
      csr_write_enable = 1'b0;
      csr_index = mrmc_pkg::CSR_JAM_RETRY_LIMIT;
      csr_write_data = '0;
      clear_prediction();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_mode_walk();
      test_insert_paths();
      test_limits_low();
      test_limits_high();
      settle();
      set_config(4'($urandom_range(4, 1)), $urandom_range(30), 8'($urandom));
      test_random_traffic(180);

      settle();
      send_gap_pct = 82;
      recv_gap_pct = 33;
      set_config(4'($urandom_range(15)), $urandom_range(200), 8'($urandom));
      test_random_traffic(180);

      settle();
      send_gap_pct = 0;
      recv_gap_pct = 0;
      test_backpressure();
      test_run_seconds();
      settle();
      set_config(4'($urandom_range(6, 2)), $urandom_range(60, 5), 8'($urandom));
      test_random_traffic(170);

      settle();
      repeat (10) @(posedge clock);
      $display("Covered %0d transactions (%0d with effect), %0d responses checked, %0d mismatches.",
               items_sent, effective_items, responses_checked, mismatch_count);
      $display("Predicted totals: %0d error entries, %0d jam entries, %0d running seconds.",
               err_count, jam_count, sec_count);
      if (mismatch_count == 0 && pending_status_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: machine_run_mode_controller.f
rtl/mrmc_pkg.sv
rtl/mrmc_req_stage.sv
rtl/mrmc_step.sv
rtl/machine_run_mode_controller.sv
dv/tb_machine_run_mode_controller.sv
